// ===== hdl/vim_pkg.sv =====
// Shared definitions for the vectored interrupt manager: command codes, register
// offsets, register group codes and default sizes.
// Depends on nothing; imported by vectored_interrupt_manager_core.
package vim_pkg;

	// Field widths of a request and its result.
	localparam int CMD_W    = 3;
	localparam int ADDR_W   = 9;
	localparam int DATA_W   = 32;
	localparam int SOURCE_W = 7;

	// Default sizes handed to the top level parameters.
	localparam int NUM_CHANNELS_DEF = 96;
	localparam int NUM_SOURCES_DEF  = 95;
	localparam int VECTOR_DEPTH_DEF = 128;

	// Widest configuration supported: four 32-bit channel words.
	localparam int MAX_WORDS = 4;
	localparam int PAD_W     = MAX_WORDS * 32;

	// Channels 0 and 1 are always FIQ and always enabled.
	localparam logic [1:0] FORCED_BITS = 2'b11;

	typedef enum logic [CMD_W-1:0] {
		CMD_REG_READ  = 3'd0,
		CMD_REG_WRITE = 3'd1,
		CMD_VEC_READ  = 3'd2,
		CMD_VEC_WRITE = 3'd3,
		CMD_SOURCE    = 3'd4
	} cmd_t;

	// Single registers, matched on the exact byte offset.
	localparam logic [ADDR_W-1:0] REG_IRQ_INDEX  = 9'h000;
	localparam logic [ADDR_W-1:0] REG_FIQ_INDEX  = 9'h004;
	localparam logic [ADDR_W-1:0] REG_IRQ_VECTOR = 9'h070;
	localparam logic [ADDR_W-1:0] REG_FIQ_VECTOR = 9'h074;
	localparam logic [ADDR_W-1:0] REG_CAPTURE    = 9'h078;
	localparam int                MAP_BASE       = 'h080;

	// Channel word groups, selected by address bits 8:4.
	localparam logic [4:0] GRP_FSEL     = 5'h01;
	localparam logic [4:0] GRP_PEND     = 5'h02;
	localparam logic [4:0] GRP_EN_SET   = 5'h03;
	localparam logic [4:0] GRP_EN_CLR   = 5'h04;
	localparam logic [4:0] GRP_WAKE_SET = 5'h05;
	localparam logic [4:0] GRP_WAKE_CLR = 5'h06;

endpackage

// ===== hdl/vectored_interrupt_manager_core.sv =====
// Vectored interrupt manager core: channel state, source mapping, priority
// selection with acknowledge, and the vector RAM.
// Depends on vim_pkg.
//
// Usage. A request is a bus command (register read or write, vector RAM read or
// write) or a source level change. It is taken at a rising edge where start is
// high and busy is low; busy is never raised, so a request may be issued in
// every cycle. Each request produces exactly one result: done is high for one
// cycle with rdata, irq_request and fiq_request on the result ports, and the
// result is taken at the edge that ends that cycle. The receiver cannot hold
// results off and need not: there is nothing to stall.
// Throughput is one request per cycle. The request is registered, then decoded and
// applied to the channel state; the vector RAM port is read while the request is
// decoded and its registered data is selected onto rdata in the result cycle, so
// the RAM read port sets the latency.
// irq_request and fiq_request show the state left by the request whose result
// is on the ports. Reset clears pending and wake bits, enables and selects only
// channels 0 and 1 as FIQ, restores the identity source map and clears the
// capture register. The vector RAM is not cleared and must be written before
// it is read.
module vectored_interrupt_manager_core #(
	parameter int NUM_CHANNELS = vim_pkg::NUM_CHANNELS_DEF,
	parameter int NUM_SOURCES  = vim_pkg::NUM_SOURCES_DEF,
	parameter int VECTOR_DEPTH = vim_pkg::VECTOR_DEPTH_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic [vim_pkg::CMD_W-1:0]     cmd,
	input  logic [vim_pkg::ADDR_W-1:0]    addr,
	input  logic [vim_pkg::DATA_W-1:0]    wdata,
	input  logic [vim_pkg::SOURCE_W-1:0]  source,
	input  logic                          level,
	output logic                          done,
	output logic [vim_pkg::DATA_W-1:0]    rdata,
	output logic                          irq_request,
	output logic                          fiq_request
);
	import vim_pkg::*;

	localparam int NUM_WORDS = (NUM_CHANNELS + 31) / 32;
	localparam int MAP_WORDS = (NUM_CHANNELS + 3) / 4;
	localparam int MAP_END   = MAP_BASE + 4 * MAP_WORDS;
	localparam int MI_W      = $clog2(MAP_WORDS);
	localparam int CH_W      = $clog2(NUM_CHANNELS);
	localparam int VA_W      = $clog2(VECTOR_DEPTH);

	// Lowest set bit of a qualified channel vector; index 0 when none is set.
	function automatic logic [CH_W:0] first_set(input logic [NUM_CHANNELS-1:0] q);
		logic [CH_W:0] r;
		r = '0;
		for (int i = NUM_CHANNELS - 1; i >= 0; i--) begin
			if (q[i]) begin
				r = {1'b1, CH_W'(i)};
			end
		end
		return r;
	endfunction

	// Request register.
	logic                 valid_s1;
	logic [CMD_W-1:0]     cmd_s1;
	logic [ADDR_W-1:0]    addr_s1;
	logic [DATA_W-1:0]    wdata_s1;
	logic [SOURCE_W-1:0]  source_s1;
	logic                 level_s1;

	// Result register.
	logic                 done_s2;
	logic [DATA_W-1:0]    rdata_s2;
	logic                 vec_sel_s2;
	logic                 vec_ok_s2;

	// Channel state.
	logic [NUM_CHANNELS-1:0] pend_q, en_q, fsel_q, wake_q;
	logic [DATA_W-1:0]       map_q [MAP_WORDS];
	logic [DATA_W-1:0]       capture_q;

	// Vector RAM and its registered read data.
	logic [DATA_W-1:0]       vec_mem [VECTOR_DEPTH];
	logic [DATA_W-1:0]       vec_rd_q;

	// Decode and next-state signals.
	logic [PAD_W-1:0]        pend_pad, en_pad, fsel_pad, wake_pad, tmp_pad;
	logic [PAD_W-1:0]        wsh, wm;
	logic [1:0]              word_idx;
	logic [6:0]              wbase;
	logic                    word_ok, grp_hit, map_hit, src_ok, vi_ok, vec_ok;
	logic [4:0]              grp;
	logic [6:0]              mi_full;
	logic [MI_W-1:0]         mi;
	logic [NUM_CHANNELS-1:0] q_irq, q_fiq, hit, ack_mask;
	logic [CH_W:0]           irq_top, fiq_top;
	logic [NUM_CHANNELS-1:0] pend_d, en_d, fsel_d, wake_d;
	logic [DATA_W-1:0]       rdata_d;
	logic                    vec_sel_d, ack_d, map_we, cap_we, vec_we;
	logic [CH_W-1:0]         ack_idx_d;
	logic [8:0]              vec_addr_d;

	assign pend_pad = PAD_W'(pend_q);
	assign en_pad   = PAD_W'(en_q);
	assign fsel_pad = PAD_W'(fsel_q);
	assign wake_pad = PAD_W'(wake_q);

	assign word_idx = addr_s1[3:2];
	assign wbase    = {word_idx, 5'b00000};
	assign word_ok  = {1'b0, word_idx} < 3'(NUM_WORDS);
	assign wsh      = PAD_W'(wdata_s1) << wbase;
	assign wm       = PAD_W'(32'hffff_ffff) << wbase;
	assign grp      = addr_s1[8:4];
	assign grp_hit  = (grp >= GRP_FSEL) && (grp <= GRP_WAKE_CLR);
	assign map_hit  = (10'(addr_s1) >= 10'(MAP_BASE)) && (10'(addr_s1) < 10'(MAP_END));
	assign mi_full  = addr_s1[8:2] - 7'(MAP_BASE / 4);
	assign mi       = mi_full[MI_W-1:0];
	assign src_ok   = {1'b0, source_s1} < 8'(NUM_SOURCES);
	assign vi_ok    = {2'b00, addr_s1[8:2]} < 9'(VECTOR_DEPTH);

	// Qualified channels of each class and their top channel.
	assign q_irq   = pend_q & en_q & ~fsel_q;
	assign q_fiq   = pend_q & en_q & fsel_q;
	assign irq_top = first_set(q_irq);
	assign fiq_top = first_set(q_fiq);

	// Channels whose map byte names the changing source; the top byte of a map
	// word belongs to the lowest channel of its group of four.
	always_comb begin
		for (int ch = 0; ch < NUM_CHANNELS; ch++) begin
			hit[ch] = map_q[ch / 4][8 * (3 - ch % 4) +: 8] == {1'b0, source_s1};
		end
	end

	always_comb begin
		rdata_d    = '0;
		vec_sel_d  = 1'b0;
		ack_d      = 1'b0;
		ack_idx_d  = irq_top[CH_W-1:0];
		vec_addr_d = {2'b00, addr_s1[8:2]};
		pend_d     = pend_q;
		en_d       = en_q;
		fsel_d     = fsel_q;
		wake_d     = wake_q;
		map_we     = 1'b0;
		cap_we     = 1'b0;
		vec_we     = 1'b0;
		tmp_pad    = '0;
		ack_mask   = '0;
		if (valid_s1) begin
			case (cmd_s1)
				CMD_REG_READ: begin
					if (grp_hit) begin
						if (word_ok) begin
							case (grp)
								GRP_FSEL:                   rdata_d = fsel_pad[wbase +: 32];
								GRP_PEND:                   rdata_d = pend_pad[wbase +: 32];
								GRP_EN_SET, GRP_EN_CLR:     rdata_d = en_pad[wbase +: 32];
								default:                    rdata_d = wake_pad[wbase +: 32];
							endcase
						end
					end else if (map_hit) begin
						rdata_d = map_q[mi];
					end else begin
						case (addr_s1)
							REG_IRQ_INDEX: begin
								rdata_d   = DATA_W'(irq_top[CH_W-1:0]);
								ack_d     = irq_top[CH_W];
								ack_idx_d = irq_top[CH_W-1:0];
							end
							REG_FIQ_INDEX: begin
								rdata_d   = DATA_W'(fiq_top[CH_W-1:0]);
								ack_d     = fiq_top[CH_W];
								ack_idx_d = fiq_top[CH_W-1:0];
							end
							REG_IRQ_VECTOR: begin
								vec_sel_d  = 1'b1;
								vec_addr_d = irq_top[CH_W] ? 9'(irq_top[CH_W-1:0]) + 9'd1 : '0;
								ack_d      = irq_top[CH_W];
								ack_idx_d  = irq_top[CH_W-1:0];
							end
							REG_FIQ_VECTOR: begin
								vec_sel_d  = 1'b1;
								vec_addr_d = fiq_top[CH_W] ? 9'(fiq_top[CH_W-1:0]) + 9'd1 : '0;
								ack_d      = fiq_top[CH_W];
								ack_idx_d  = fiq_top[CH_W-1:0];
							end
							REG_CAPTURE: rdata_d = capture_q;
							default:     rdata_d = '0;
						endcase
					end
				end
				CMD_REG_WRITE: begin
					if (grp_hit) begin
						if (word_ok) begin
							case (grp)
								GRP_FSEL: begin
									tmp_pad = (fsel_pad & ~wm) | wsh | PAD_W'(FORCED_BITS);
									fsel_d  = tmp_pad[NUM_CHANNELS-1:0];
								end
								GRP_PEND: begin
									tmp_pad = pend_pad & ~wsh;
									pend_d  = tmp_pad[NUM_CHANNELS-1:0];
								end
								GRP_EN_SET: begin
									tmp_pad = en_pad | wsh;
									en_d    = tmp_pad[NUM_CHANNELS-1:0];
								end
								GRP_EN_CLR: begin
									tmp_pad = (en_pad & ~wsh) | PAD_W'(FORCED_BITS);
									en_d    = tmp_pad[NUM_CHANNELS-1:0];
								end
								GRP_WAKE_SET: begin
									tmp_pad = wake_pad | wsh;
									wake_d  = tmp_pad[NUM_CHANNELS-1:0];
								end
								default: begin
									tmp_pad = wake_pad & ~wsh;
									wake_d  = tmp_pad[NUM_CHANNELS-1:0];
								end
							endcase
						end
					end else if (map_hit) begin
						map_we = 1'b1;
					end else if (addr_s1 == REG_CAPTURE) begin
						cap_we = 1'b1;
					end
				end
				CMD_VEC_READ:  vec_sel_d = 1'b1;
				CMD_VEC_WRITE: vec_we = vi_ok;
				CMD_SOURCE: begin
					if (src_ok) begin
						pend_d = level_s1 ? (pend_q | hit) : (pend_q & ~hit);
					end
				end
				default: rdata_d = '0;
			endcase
			// Acknowledge clears the top channel after its value has been taken.
			if (ack_d) begin
				ack_mask = NUM_CHANNELS'(1) << ack_idx_d;
				pend_d   = pend_q & ~ack_mask;
			end
		end
	end

	assign vec_ok = vec_addr_d < 9'(VECTOR_DEPTH);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1   <= 1'b0;
			done_s2    <= 1'b0;
			vec_sel_s2 <= 1'b0;
			vec_ok_s2  <= 1'b0;
			pend_q     <= '0;
			wake_q     <= '0;
			en_q       <= NUM_CHANNELS'(FORCED_BITS);
			fsel_q     <= NUM_CHANNELS'(FORCED_BITS);
			capture_q  <= '0;
			for (int i = 0; i < MAP_WORDS; i++) begin
				map_q[i] <= {8'(4 * i), 8'(4 * i + 1), 8'(4 * i + 2), 8'(4 * i + 3)};
			end
		end else begin
			valid_s1   <= start && !busy;
			done_s2    <= valid_s1;
			vec_sel_s2 <= vec_sel_d;
			vec_ok_s2  <= vec_ok;
			pend_q     <= pend_d;
			en_q       <= en_d;
			fsel_q     <= fsel_d;
			wake_q     <= wake_d;
			if (cap_we) begin
				capture_q <= wdata_s1;
			end
			if (map_we) begin
				map_q[mi] <= wdata_s1;
			end
		end
	end

	// Request and result payload.
	always_ff @(posedge clk) begin
		if (start && !busy) begin
			cmd_s1    <= cmd;
			addr_s1   <= addr;
			wdata_s1  <= wdata;
			source_s1 <= source;
			level_s1  <= level;
		end
		rdata_s2 <= rdata_d;
	end

	// Vector RAM: one write port, one registered read port.
	always_ff @(posedge clk) begin
		if (vec_we) begin
			vec_mem[vec_addr_d[VA_W-1:0]] <= wdata_s1;
		end
		vec_rd_q <= vec_mem[vec_addr_d[VA_W-1:0]];
	end

	assign busy        = 1'b0;
	assign done        = done_s2;
	assign rdata       = vec_sel_s2 ? (vec_ok_s2 ? vec_rd_q : '0) : rdata_s2;
	assign irq_request = |q_irq;
	assign fiq_request = |q_fiq;

endmodule

// ===== dv/tb_vectored_interrupt_manager_core.sv =====
// Self-checking testbench for vectored_interrupt_manager_core: directed and random bus
// requests and source changes, checked against a cycle-free predictor of the channel state.
// Depends on vim_pkg and the core RTL only.
module tb_vectored_interrupt_manager_core;
	timeunit 1ns;
	timeprecision 1ps;

	import vim_pkg::*;

	// Sizes of the instance under test, and the word counts that follow from them.
	localparam int NUM_CH    = NUM_CHANNELS_DEF;
	localparam int NUM_SRC   = NUM_SOURCES_DEF;
	localparam int VEC_DEPTH = VECTOR_DEPTH_DEF;
	localparam int NUM_WORDS = (NUM_CH + 31) / 32;
	localparam int MAP_WORDS = (NUM_CH + 3) / 4;

	// Command codes that the block must treat as no operation.
	localparam logic [CMD_W-1:0] CMD_RESERVED_LO = 3'd5;
	localparam logic [CMD_W-1:0] CMD_RESERVED_HI = 3'd7;

	// Offsets used by the directed part that have no name in the package.
	localparam logic [ADDR_W-1:0] OFS_FSEL0      = 9'h010;
	localparam logic [ADDR_W-1:0] OFS_FSEL3      = 9'h01c;
	localparam logic [ADDR_W-1:0] OFS_PEND2      = 9'h028;
	localparam logic [ADDR_W-1:0] OFS_EN_SET2    = 9'h038;
	localparam logic [ADDR_W-1:0] OFS_EN_CLR0    = 9'h040;
	localparam logic [ADDR_W-1:0] OFS_WAKE_SET1  = 9'h054;
	localparam logic [ADDR_W-1:0] OFS_WAKE_CLR1  = 9'h064;
	localparam logic [ADDR_W-1:0] OFS_GAP        = 9'h00c;
	localparam logic [ADDR_W-1:0] OFS_AFTER_CAPT = 9'h07c;
	localparam logic [ADDR_W-1:0] OFS_MAP_FIRST  = 9'h080;
	localparam logic [ADDR_W-1:0] OFS_MAP_LAST   = 9'h0dc;
	localparam logic [ADDR_W-1:0] OFS_PAST_MAP   = 9'h0e0;

	// What one result of the block carries.
	typedef struct packed {
		logic [DATA_W-1:0] rdata;
		logic              irq;
		logic              fiq;
	} response_t;

	// Holds a private copy of the channel state, works out the result of every accepted
	// request and compares the results that the block produces, oldest first.
	class interrupt_scoreboard;
		bit [31:0]     pend      [NUM_WORDS];
		bit [31:0]     enable    [NUM_WORDS];
		bit [31:0]     fiq_sel   [NUM_WORDS];
		bit [31:0]     wake      [NUM_WORDS];
		bit [31:0]     chan_map  [MAP_WORDS];
		bit [31:0]     capture;
		bit [31:0]     vec_ram   [VEC_DEPTH];
		bit            vec_known [VEC_DEPTH];
		response_t     awaited[$];
		int unsigned   errors;

		function new();
			int i;
			for (i = 0; i < NUM_WORDS; i++) begin
				pend[i]    = '0;
				enable[i]  = '0;
				fiq_sel[i] = '0;
				wake[i]    = '0;
			end
			enable[0]  = 32'(FORCED_BITS);
			fiq_sel[0] = 32'(FORCED_BITS);
			for (i = 0; i < MAP_WORDS; i++)
				chan_map[i] = {8'(4*i), 8'(4*i+1), 8'(4*i+2), 8'(4*i+3)};
			for (i = 0; i < VEC_DEPTH; i++) begin
				vec_ram[i]   = '0;
				vec_known[i] = 1'b0;
			end
			capture = '0;
			errors  = 0;
		endfunction

		function bit [31:0] lane_mask(int w);
			int left;
			left = NUM_CH - 32 * w;
			if (left >= 32)
				return '1;
			return (32'h1 << left) - 32'h1;
		endfunction

		// Lowest channel of the class that is pending and enabled, or -1.
		function int lowest_qualified(bit fiq);
			int c;
			bit sel;
			for (c = 0; c < NUM_CH; c++) begin
				sel = fiq ? fiq_sel[c/32][c%32] : !fiq_sel[c/32][c%32];
				if (pend[c/32][c%32] && enable[c/32][c%32] && sel)
					return c;
			end
			return -1;
		endfunction

		function bit [31:0] vector_for(int ch);
			int idx;
			idx = (ch < 0) ? 0 : ch + 1;
			return (idx < VEC_DEPTH) ? vec_ram[idx] : 32'h0;
		endfunction

		function void clear_channel(int ch);
			if (ch >= 0 && ch < NUM_CH)
				pend[ch/32][ch%32] = 1'b0;
		endfunction

		// True when the request would read a vector entry that was never written.
		function bit hits_unwritten(logic [CMD_W-1:0] c, logic [ADDR_W-1:0] a, output int entry);
			int ch;
			entry = 0;
			if (c == CMD_VEC_READ)
				entry = int'(a[8:2]);
			else if (c == CMD_REG_READ && (a == REG_IRQ_VECTOR || a == REG_FIQ_VECTOR)) begin
				ch    = lowest_qualified(a == REG_FIQ_VECTOR);
				entry = (ch < 0) ? 0 : ch + 1;
			end else
				return 1'b0;
			return entry < VEC_DEPTH && !vec_known[entry];
		endfunction

		function bit [31:0] read_register(logic [ADDR_W-1:0] a);
			logic [4:0] grp;
			int         w;
			int         ch;
			bit [31:0]  v;
			grp = a[8:4];
			w   = int'(a[3:2]);
			if (grp >= GRP_FSEL && grp <= GRP_WAKE_CLR) begin
				if (w >= NUM_WORDS)
					return '0;
				case (grp)
					GRP_FSEL:             return fiq_sel[w];
					GRP_PEND:             return pend[w];
					GRP_EN_SET, GRP_EN_CLR: return enable[w];
					default:              return wake[w];
				endcase
			end
			if (int'(a) >= MAP_BASE && int'(a) < MAP_BASE + 4 * MAP_WORDS)
				return chan_map[(int'(a) - MAP_BASE) >> 2];
			case (a)
				REG_IRQ_INDEX, REG_FIQ_INDEX: begin
					ch = lowest_qualified(a == REG_FIQ_INDEX);
					clear_channel(ch);
					return (ch < 0) ? 32'h0 : 32'(ch);
				end
				REG_IRQ_VECTOR, REG_FIQ_VECTOR: begin
					ch = lowest_qualified(a == REG_FIQ_VECTOR);
					v  = vector_for(ch);
					clear_channel(ch);
					return v;
				end
				REG_CAPTURE: return capture;
				default:     return '0;
			endcase
		endfunction

		function void write_register(logic [ADDR_W-1:0] a, bit [31:0] d);
			logic [4:0] grp;
			int         w;
			bit [31:0]  keep;
			grp  = a[8:4];
			w    = int'(a[3:2]);
			keep = (w == 0) ? 32'(FORCED_BITS) : 32'h0;
			if (grp >= GRP_FSEL && grp <= GRP_WAKE_CLR) begin
				if (w >= NUM_WORDS)
					return;
				case (grp)
					GRP_FSEL:     fiq_sel[w] = (d | keep) & lane_mask(w);
					GRP_PEND:     pend[w] &= ~d;
					GRP_EN_SET:   enable[w] = (enable[w] | d) & lane_mask(w);
					GRP_EN_CLR:   enable[w] &= ~d | keep;
					GRP_WAKE_SET: wake[w] = (wake[w] | d) & lane_mask(w);
					default:      wake[w] &= ~d;
				endcase
			end else if (int'(a) >= MAP_BASE && int'(a) < MAP_BASE + 4 * MAP_WORDS)
				chan_map[(int'(a) - MAP_BASE) >> 2] = d;
			else if (a == REG_CAPTURE)
				capture = d;
		endfunction

		function void change_source(logic [SOURCE_W-1:0] s, logic l);
			int c;
			if (int'(s) >= NUM_SRC)
				return;
			for (c = 0; c < NUM_CH; c++)
				if (chan_map[c/4][8*(3 - c%4) +: 8] == 8'(s))
					pend[c/32][c%32] = l;
		endfunction

		function void note_request(logic [CMD_W-1:0] c, logic [ADDR_W-1:0] a,
				logic [DATA_W-1:0] d, logic [SOURCE_W-1:0] s, logic l);
			response_t r;
			r.rdata = '0;
			case (c)
				CMD_REG_READ:  r.rdata = read_register(a);
				CMD_REG_WRITE: write_register(a, d);
				CMD_VEC_READ:  if (int'(a[8:2]) < VEC_DEPTH) r.rdata = vec_ram[a[8:2]];
				CMD_VEC_WRITE: if (int'(a[8:2]) < VEC_DEPTH) begin
					vec_ram[a[8:2]]   = d;
					vec_known[a[8:2]] = 1'b1;
				end
				CMD_SOURCE:    change_source(s, l);
				default:       ;
			endcase
			r.irq = lowest_qualified(1'b0) >= 0;
			r.fiq = lowest_qualified(1'b1) >= 0;
			awaited.push_back(r);
		endfunction

		function void report(string what, logic [31:0] want, logic [31:0] got);
			errors++;
			$display("%0t: %s mismatch, expected %h, got %h", $time, what, want, got);
		endfunction

		function void check_result(logic [DATA_W-1:0] rd, logic irq, logic fiq);
			response_t want;
			if (awaited.size() == 0) begin
				errors++;
				$display("%0t: result with nothing outstanding, rdata %h", $time, rd);
				return;
			end
			want = awaited.pop_front();
			if (rd !== want.rdata)
				report("rdata", want.rdata, rd);
			if (irq !== want.irq)
				report("irq_request", 32'(want.irq), 32'(irq));
			if (fiq !== want.fiq)
				report("fiq_request", 32'(want.fiq), 32'(fiq));
		endfunction

		function void close_out();
			if (awaited.size() != 0) begin
				errors += awaited.size();
				$display("%0t: %0d expected results never arrived", $time, awaited.size());
			end
		endfunction
	endclass

	logic                clk;
	logic                arst_n;
	logic                start;
	logic                busy;
	logic [CMD_W-1:0]    cmd;
	logic [ADDR_W-1:0]   addr;
	logic [DATA_W-1:0]   wdata;
	logic [SOURCE_W-1:0] source;
	logic                level;
	logic                done;
	logic [DATA_W-1:0]   rdata;
	logic                irq_request;
	logic                fiq_request;

	interrupt_scoreboard sb = new();

	vectored_interrupt_manager_core dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.cmd         (cmd),
		.addr        (addr),
		.wdata       (wdata),
		.source      (source),
		.level       (level),
		.done        (done),
		.rdata       (rdata),
		.irq_request (irq_request),
		.fiq_request (fiq_request)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// A generous ceiling: the slowest legal run, with every request followed by the
	// longest gap, needs less than a seventh of this.
	initial begin
		#1_000_000;
		$display("Simulation FAILED");
		$finish;
	end

	// Every strobed result is taken at the rising edge that ends its cycle; the outputs
	// are read before the block's own flops update at that edge.
	always @(posedge clk) begin
		if (arst_n && done)
			sb.check_result(rdata, irq_request, fiq_request);
	end

	// Drives one request at the falling edge and holds it until an edge with busy low
	// takes it. A read that would touch a vector entry never written is turned into a
	// write of that entry, so the undefined contents of the RAM are never observed.
	task automatic send(logic [CMD_W-1:0] c, logic [ADDR_W-1:0] a, logic [DATA_W-1:0] d,
			logic [SOURCE_W-1:0] s, logic l);
		int entry;
		if (sb.hits_unwritten(c, a, entry)) begin
			c = CMD_VEC_WRITE;
			a = ADDR_W'(entry * 4);
		end
		@(negedge clk);
		start  <= 1'b1;
		cmd    <= c;
		addr   <= a;
		wdata  <= d;
		source <= s;
		level  <= l;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		sb.note_request(c, a, d, s, l);
	endtask

	// Leaves start low for a gap of length n. The other fields are scrambled meanwhile, which the
	// block must ignore.
	task automatic idle(int n);
		if (n > 0) begin
			@(negedge clk);
			start <= 1'b0;
			cmd   <= CMD_W'($urandom);
			addr  <= ADDR_W'($urandom);
			wdata <= $urandom;
			repeat (n - 1)
				@(negedge clk);
		end
	endtask

	// Stops sending and waits until every outstanding result has been seen.
	task automatic wait_for_responses();
		int n;
		@(negedge clk);
		start <= 1'b0;
		for (n = 0; n < 1000 && sb.awaited.size() != 0; n++)
			@(posedge clk);
	endtask

	// A register offset from any region: channel words, the map, the single registers,
	// or anywhere in the address space, so the holes are reached too.
	function automatic logic [ADDR_W-1:0] any_register_offset();
		int r;
		r = $urandom_range(0, 9);
		if (r < 4)
			return OFS_FSEL0 + ADDR_W'($urandom_range(0, 'h5f));
		if (r < 6)
			return OFS_MAP_FIRST + ADDR_W'($urandom_range(0, 4 * MAP_WORDS - 1));
		if (r < 8) begin
			case ($urandom_range(0, 4))
				0:       return REG_IRQ_INDEX;
				1:       return REG_FIQ_INDEX;
				2:       return REG_IRQ_VECTOR;
				3:       return REG_FIQ_VECTOR;
				default: return REG_CAPTURE;
			endcase
		end
		return ADDR_W'($urandom);
	endfunction

	// One random request. Source changes and acknowledging reads dominate, so channels
	// keep being raised and served; the rest configures the channels, the map and the
	// vector RAM, or probes offsets that must be ignored.
	task automatic random_request();
		logic [CMD_W-1:0]    c;
		logic [ADDR_W-1:0]   a;
		logic [DATA_W-1:0]   d;
		logic [SOURCE_W-1:0] s;
		logic                l;
		int                  r;
		int                  k;
		a = ADDR_W'($urandom);
		d = $urandom;
		s = SOURCE_W'($urandom_range(0, NUM_SRC - 1));
		l = $urandom_range(0, 99) < 60;
		r = $urandom_range(0, 99);
		if (r < 30) begin
			c = CMD_SOURCE;
			if ($urandom_range(0, 19) == 0)
				s = SOURCE_W'($urandom_range(NUM_SRC, 127));
		end else if (r < 45) begin
			c = CMD_REG_READ;
			case ($urandom_range(0, 3))
				0:       a = REG_IRQ_INDEX;
				1:       a = REG_FIQ_INDEX;
				2:       a = REG_IRQ_VECTOR;
				default: a = REG_FIQ_VECTOR;
			endcase
		end else if (r < 60) begin
			c = CMD_REG_WRITE;
			a = OFS_FSEL0 + ADDR_W'($urandom_range(0, 'h5f));
		end else if (r < 65) begin
			// Map bytes mostly name a real source; the rest are random bytes.
			c = CMD_REG_WRITE;
			a = OFS_MAP_FIRST + ADDR_W'($urandom_range(0, 4 * MAP_WORDS - 1));
			for (k = 0; k < 4; k++)
				d[8*k +: 8] = ($urandom_range(0, 3) != 0) ?
					8'($urandom_range(0, NUM_SRC - 1)) : 8'($urandom);
		end else if (r < 75) begin
			c = CMD_REG_READ;
			a = any_register_offset();
		end else if (r < 79) begin
			c = CMD_REG_WRITE;
			a = any_register_offset();
		end else if (r < 89)
			c = CMD_VEC_WRITE;
		else if (r < 98)
			c = CMD_VEC_READ;
		else
			c = CMD_W'($urandom_range(CMD_RESERVED_LO, CMD_RESERVED_HI));
		send(c, a, d, s, l);
	endtask

	initial begin
		int  i;
		int  r;
		int  gap;
		bit  steady;
		arst_n = 1'b0;
		start  = 1'b0;
		cmd    = CMD_REG_READ;
		addr   = '0;
		wdata  = '0;
		source = '0;
		level  = 1'b0;
		repeat (6)
			@(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed part. An acknowledge with nothing pending comes first, then the vector
		// RAM extremes, the forced FIQ channels, the top channel, the read-only and
		// undecoded offsets, out-of-range sources, map bytes that name no source, and
		// a reserved command.
		send(CMD_REG_READ,  REG_IRQ_INDEX,  '0,            '0, 1'b0);
		send(CMD_VEC_WRITE, 9'h000,         32'hffff_ffff, '0, 1'b0);
		send(CMD_VEC_WRITE, 9'h004,         32'h0000_0000, '0, 1'b0);
		send(CMD_VEC_WRITE, 9'h1fc,         32'h8000_0001, '0, 1'b0);
		send(CMD_VEC_READ,  9'h1ff,         '0,            '0, 1'b0);
		send(CMD_REG_READ,  REG_IRQ_VECTOR, '0,            '0, 1'b0);
		send(CMD_SOURCE,    '0,             '0,            7'd0, 1'b1);
		send(CMD_REG_READ,  REG_FIQ_VECTOR, '0,            '0, 1'b0);
		send(CMD_SOURCE,    '0,             '0,            7'(NUM_SRC - 1), 1'b1);
		send(CMD_REG_WRITE, OFS_EN_SET2,    32'hffff_ffff, '0, 1'b0);
		send(CMD_REG_READ,  REG_IRQ_INDEX,  '0,            '0, 1'b0);
		send(CMD_REG_WRITE, OFS_FSEL0,      32'h0000_0000, '0, 1'b0);
		send(CMD_REG_WRITE, OFS_EN_CLR0,    32'hffff_ffff, '0, 1'b0);
		send(CMD_REG_READ,  OFS_FSEL0 + 9'h3, '0,          '0, 1'b0);
		send(CMD_SOURCE,    '0,             '0,            7'(NUM_SRC), 1'b1);
		send(CMD_REG_WRITE, OFS_MAP_FIRST,  32'hffff_ffff, '0, 1'b0);
		send(CMD_REG_WRITE, OFS_MAP_LAST,   32'h0000_0000, '0, 1'b0);
		send(CMD_SOURCE,    '0,             '0,            7'd0, 1'b1);
		send(CMD_REG_WRITE, OFS_PEND2,      32'hffff_ffff, '0, 1'b0);
		send(CMD_REG_WRITE, OFS_WAKE_SET1,  32'hffff_ffff, '0, 1'b0);
		send(CMD_REG_WRITE, OFS_WAKE_CLR1,  32'h0000_ffff, '0, 1'b0);
		send(CMD_REG_WRITE, REG_CAPTURE,    32'hdead_beef, '0, 1'b0);
		send(CMD_REG_WRITE, REG_FIQ_INDEX,  32'hffff_ffff, '0, 1'b0);
		send(CMD_REG_WRITE, OFS_AFTER_CAPT, 32'hffff_ffff, '0, 1'b0);
		send(CMD_REG_READ,  OFS_GAP,        '0,            '0, 1'b0);
		send(CMD_REG_READ,  OFS_FSEL3,      '0,            '0, 1'b0);
		send(CMD_REG_READ,  OFS_PAST_MAP,   '0,            '0, 1'b0);
		send(CMD_RESERVED_HI, REG_CAPTURE,  32'hffff_ffff, 7'h7f, 1'b1);
		send(CMD_SOURCE,    '0,             '0,            7'd0, 1'b0);
		wait_for_responses();

		// Random part. The sender runs in stretches of a hundred requests, some with no
		// gaps at all and the rest mostly without, with some short and few long gaps. Every
		// four hundred requests it stops until all results are in.
		steady = 1'b0;
		for (i = 0; i < 1600; i++) begin
			if (i % 100 == 0)
				steady = $urandom_range(0, 3) == 0;
			if (i % 400 == 399)
				wait_for_responses();
			random_request();
			gap = 0;
			if (!steady) begin
				r = $urandom_range(0, 99);
				if (r >= 93)
					gap = $urandom_range(8, 40);
				else if (r >= 65)
					gap = $urandom_range(1, 3);
			end
			idle(gap);
		end

		// Drain, then keep watching for stray strobes before closing out.
		wait_for_responses();
		repeat (4)
			@(posedge clk);
		sb.close_out();
		if (sb.errors == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
